/* rtl/pmct_pkg.sv */
// Shared types and constants for the PS/2 mouse cursor tracker.
// No dependencies; used by pmct_core and ps2_mouse_cursor_tracker.
`default_nettype none

package pmct_pkg;

    // Default screen geometry and pointer units per text cell.
    localparam int DEF_SCREEN_COLS      = 80;
    localparam int DEF_SCREEN_ROWS      = 25;
    localparam int DEF_X_UNITS_PER_CELL = 4;
    localparam int DEF_Y_UNITS_PER_CELL = 8;

    // Field widths fixed by the interface.
    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 12;
    localparam int POSX_W = 9;
    localparam int POSY_W = 8;

    // Pointer position limits and reset position.
    localparam logic [POSX_W-1:0] POS_X_MAX   = 9'd319;
    localparam logic [POSY_W-1:0] POS_Y_MAX   = 8'd199;
    localparam logic [POSX_W-1:0] POS_X_RESET = 9'd179;
    localparam logic [POSY_W-1:0] POS_Y_RESET = 8'd100;

    // Protocol bytes.
    localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'hFA;
    localparam logic [BYTE_W-1:0] HDR_LEFT   = 8'h09;
    localparam logic [BYTE_W-1:0] HDR_RIGHT  = 8'h0A;
    localparam logic [BYTE_W-1:0] HDR_MIDDLE = 8'h0C;
    localparam logic [BYTE_W-1:0] HDR_IDLE   = 8'h08;
    localparam logic [BYTE_W-1:0] SIGN_X     = 8'h10;
    localparam logic [BYTE_W-1:0] SIGN_Y     = 8'h20;

    typedef enum logic [1:0] {
        EV_READY = 2'd0,
        EV_LEFT  = 2'd1,
        EV_RIGHT = 2'd2,
        EV_MOVE  = 2'd3
    } event_kind_t;

    // One cursor event as produced by the packet core.
    typedef struct packed {
        event_kind_t      kind;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] prev_col;
        logic [ROW_W-1:0] prev_row;
    } pmct_event_t;

endpackage

`default_nettype wire

/* rtl/pmct_core.sv */
// Packet assembly, pointer accumulation and text-cell mapping for one received byte.
// Depends on pmct_pkg; instantiated by ps2_mouse_cursor_tracker.
`default_nettype none

module pmct_core
    import pmct_pkg::*;
#(
    parameter int SCREEN_COLS      = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS      = DEF_SCREEN_ROWS,
    parameter int X_UNITS_PER_CELL = DEF_X_UNITS_PER_CELL,
    parameter int Y_UNITS_PER_CELL = DEF_Y_UNITS_PER_CELL
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output logic                   evt_valid,
    output pmct_event_t            evt
);

    // Division by the cell size is a multiply by a rounded-up reciprocal. With an
    // 18-bit shift the quotient is exact for every dividend below 512.
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] X_RECIP =
        RECIP_W'((2**RECIP_SHIFT + X_UNITS_PER_CELL - 1) / X_UNITS_PER_CELL);
    localparam logic [RECIP_W-1:0] Y_RECIP =
        RECIP_W'((2**RECIP_SHIFT + Y_UNITS_PER_CELL - 1) / Y_UNITS_PER_CELL);
    localparam logic [POSX_W-1:0] COL_LAST = POSX_W'(SCREEN_COLS - 1);
    localparam logic [POSY_W-1:0] ROW_LAST = POSY_W'(SCREEN_ROWS - 1);

    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_DX     = 2'd1;
    localparam logic [1:0] IDX_DY     = 2'd2;

    logic              enabled_reg,  enabled_next;
    logic [1:0]        byte_idx_reg, byte_idx_next;
    logic [BYTE_W-1:0] header_reg,   header_next;
    logic [BYTE_W-1:0] dx_reg,       dx_next;
    logic [POSX_W-1:0] pos_x_reg,    pos_x_next;
    logic [POSY_W-1:0] pos_y_reg,    pos_y_next;
    logic [COL_W-1:0]  cur_col_reg,  cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg,  cur_row_next;

    logic signed [10:0]            nx, ny, dx9, dy9;
    logic [POSX_W-1:0]             nx_sat;
    logic [POSY_W-1:0]             ny_sat;
    logic [POSX_W+RECIP_W-1:0]     col_prod;
    logic [POSY_W+RECIP_W-1:0]     row_prod;
    logic [POSX_W-1:0]             col_q;
    logic [POSY_W-1:0]             row_q;
    logic [COL_W-1:0]              col_new;
    logic [ROW_W-1:0]              row_new;

    // Motion arithmetic, evaluated for every byte and used only on a movement packet.
    always_comb
    begin
        dx9 = signed'({{2{(header_reg & SIGN_X) != '0}}, (header_reg & SIGN_X) != '0, dx_reg});
        dy9 = signed'({{2{(header_reg & SIGN_Y) != '0}}, (header_reg & SIGN_Y) != '0, rx_byte});
        nx  = signed'({2'b00, pos_x_reg}) + dx9;
        ny  = signed'({3'b000, pos_y_reg}) - dy9;

        if (nx < 0)
            nx_sat = '0;
        else if (nx > signed'({2'b00, POS_X_MAX}))
            nx_sat = POS_X_MAX;
        else
            nx_sat = nx[POSX_W-1:0];

        if (ny < 0)
            ny_sat = '0;
        else if (ny > signed'({3'b000, POS_Y_MAX}))
            ny_sat = POS_Y_MAX;
        else
            ny_sat = ny[POSY_W-1:0];

        col_prod = {{RECIP_W{1'b0}}, nx_sat} * {{POSX_W{1'b0}}, X_RECIP};
        row_prod = {{RECIP_W{1'b0}}, ny_sat} * {{POSY_W{1'b0}}, Y_RECIP};
        col_q    = col_prod[RECIP_SHIFT +: POSX_W];
        row_q    = row_prod[RECIP_SHIFT +: POSY_W];
        col_new  = (col_q > COL_LAST) ? COL_LAST[COL_W-1:0] : col_q[COL_W-1:0];
        row_new  = (row_q > ROW_LAST) ? ROW_LAST[ROW_W-1:0] : row_q[ROW_W-1:0];
    end

    always_comb
    begin
        enabled_next  = enabled_reg;
        byte_idx_next = byte_idx_reg;
        header_next   = header_reg;
        dx_next       = dx_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;

        evt_valid    = 1'b0;
        evt.kind     = EV_READY;
        evt.col      = cur_col_reg;
        evt.row      = cur_row_reg;
        evt.prev_col = cur_col_reg;
        evt.prev_row = cur_row_reg;

        if (!enabled_reg && rx_byte == ACK_BYTE)
        begin
            enabled_next = 1'b1;
            evt_valid    = 1'b1;
        end
        else if (byte_idx_reg == IDX_DX)
        begin
            dx_next       = rx_byte;
            byte_idx_next = IDX_DY;
        end
        else if (byte_idx_reg == IDX_DY)
        begin
            byte_idx_next = IDX_HEADER;
            if (header_reg == HDR_LEFT)
            begin
                evt_valid = 1'b1;
                evt.kind  = EV_LEFT;
            end
            else if (header_reg == HDR_RIGHT)
            begin
                evt_valid = 1'b1;
                evt.kind  = EV_RIGHT;
            end
            else if (header_reg == HDR_MIDDLE)
            begin
                evt_valid = 1'b0;
            end
            else if (header_reg == HDR_IDLE && dx_reg == '0 && rx_byte == '0)
            begin
                evt_valid = 1'b0;
            end
            else
            begin
                pos_x_next   = nx_sat;
                pos_y_next   = ny_sat;
                cur_col_next = col_new;
                cur_row_next = row_new;
                evt_valid    = 1'b1;
                evt.kind     = EV_MOVE;
                evt.col      = col_new;
                evt.row      = row_new;
            end
        end
        else
        begin
            // An index that never occurs in operation is handled as a packet start.
            header_next   = rx_byte;
            byte_idx_next = IDX_DX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            byte_idx_reg <= IDX_HEADER;
            header_reg   <= '0;
            dx_reg       <= '0;
            pos_x_reg    <= POS_X_RESET;
            pos_y_reg    <= POS_Y_RESET;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
        end
        else if (fire)
        begin
            enabled_reg  <= enabled_next;
            byte_idx_reg <= byte_idx_next;
            header_reg   <= header_next;
            dx_reg       <= dx_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            cur_col_reg  <= cur_col_next;
            cur_row_reg  <= cur_row_next;
        end
    end

`ifndef SYNTHESIS
    // Once the device has acknowledged, it stays enabled.
    assert property (@(posedge clk) disable iff (!rst_n) enabled_reg |=> enabled_reg)
        else $error("pmct_core: enabled flag cleared");

    // The packet index never reaches its unused code.
    assert property (@(posedge clk) disable iff (!rst_n) byte_idx_reg != 2'd3)
        else $error("pmct_core: packet index out of range");

    // The stored pointer position stays inside the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_x_reg <= POS_X_MAX && pos_y_reg <= POS_Y_MAX)
        else $error("pmct_core: pointer position out of range");
`endif

endmodule

`default_nettype wire

/* rtl/ps2_mouse_cursor_tracker.sv */
// Top level of the PS/2 mouse cursor tracker: input register, event register and
// output register around pmct_core. Depends on pmct_pkg and pmct_core.
//
//  Channel  | Direction | tdata                          | tuser        | tlast
//  ---------+-----------+--------------------------------+--------------+------
//  s_axis   | in        | rx_byte [7:0]                  | -            | -
//  m_axis   | out       | col,row,prev col/row,address   | event_kind   | -
//
// One byte is accepted every cycle until a stalled output has filled the stages behind it.
// The path has three register stages: input byte, decoded event, and
// output with the cell address computed from the registered cell.
// After reset the pointer is at (179, 100), the cell at column 0, row 0, and the
// device is not enabled. A stalled output holds its transaction; the two inner
// stages keep accepting until every stage is full.
`default_nettype none

module ps2_mouse_cursor_tracker
    import pmct_pkg::*;
#(
    parameter int SCREEN_COLS      = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS      = DEF_SCREEN_ROWS,
    parameter int X_UNITS_PER_CELL = DEF_X_UNITS_PER_CELL,
    parameter int Y_UNITS_PER_CELL = DEF_Y_UNITS_PER_CELL
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] cell_col, [11:7] cell_row, [18:12] prev_col, [23:19] prev_row,
    // [35:24] cell_address, [39:36] zero
    output logic [39:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser    // [1:0] event_kind
);

    localparam int ROW_BYTES_W = 9;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES = ROW_BYTES_W'(2 * SCREEN_COLS);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              s2_valid_reg;
    pmct_event_t       s2_evt_reg;
    logic              out_valid_reg;
    pmct_event_t       out_evt_reg;
    logic [ADDR_W-1:0] out_addr_reg;

    logic              s1_fire, s2_free, s2_move, out_free;
    logic              core_valid;
    pmct_event_t       core_evt;
    logic [ROW_W+ROW_BYTES_W-1:0] addr_sum;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s2_move       = s2_valid_reg && out_free;
    assign s2_free       = !s2_valid_reg || s2_move;
    assign s1_fire       = in_valid_reg && s2_free;
    assign s_axis_tready = !in_valid_reg || s1_fire;

    pmct_core #(
        .SCREEN_COLS      (SCREEN_COLS),
        .SCREEN_ROWS      (SCREEN_ROWS),
        .X_UNITS_PER_CELL (X_UNITS_PER_CELL),
        .Y_UNITS_PER_CELL (Y_UNITS_PER_CELL)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .rx_byte   (in_byte_reg),
        .evt_valid (core_valid),
        .evt       (core_evt)
    );

    // The address wraps to its low twelve bits.
    assign addr_sum = {{(ROW_W+ROW_BYTES_W-COL_W-1){1'b0}}, s2_evt_reg.col, 1'b0}
                    + {{ROW_BYTES_W{1'b0}}, s2_evt_reg.row}
                      * {{ROW_W{1'b0}}, ROW_BYTES};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (s1_fire)
                in_valid_reg <= 1'b0;

            if (s1_fire)
                s2_valid_reg <= core_valid;
            else if (s2_move)
                s2_valid_reg <= 1'b0;

            if (s2_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
        if (s1_fire && core_valid)
            s2_evt_reg <= core_evt;
        if (s2_move)
        begin
            out_evt_reg  <= s2_evt_reg;
            out_addr_reg <= addr_sum[ADDR_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_evt_reg.kind;
    assign m_axis_tdata  = {4'b0000, out_addr_reg, out_evt_reg.prev_row,
                            out_evt_reg.prev_col, out_evt_reg.row, out_evt_reg.col};

`ifndef SYNTHESIS
    // A column beyond the screen width is never reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[6:0]) < 32'(SCREEN_COLS)))
        else $error("tracker: reported column outside the screen");

    // Ready and click events leave the cursor where it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != EV_MOVE)
        |-> (m_axis_tdata[18:12] == m_axis_tdata[6:0]
             && m_axis_tdata[23:19] == m_axis_tdata[11:7]))
        else $error("tracker: non-moving event changed the cell");

    // A decoded event waiting for the output stage is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_move) |=> s2_valid_reg)
        else $error("tracker: pending event lost");

    // The input stage only refuses bytes while it holds one and the event stage is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && s2_valid_reg))
        else $error("tracker: input stalled without cause");
`endif

endmodule

`default_nettype wire
